// ===== sv/msr_pkg.sv =====
package msr_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED,
    S_DISP,
    S_POW,
    S_MUL,
    S_MULW,
    S_POWW,
    S_C3,
    S_QS,
    S_ZTEST,
    S_ZNEXT,
    S_CQ,
    S_TQ,
    S_RQ,
    S_LOOP,
    S_KSQ,
    S_KCHK,
    S_BSQ,
    S_UPD1,
    S_UPD2,
    S_UPD3,
    S_DONE
  } state_t;

  // what to do once an exponentiation finishes
  typedef enum logic [2:0] {
    P_C3,
    P_Z,
    P_C,
    P_T,
    P_R
  } pdest_t;

endpackage

// ===== sv/msr_mulmod.sv =====
// bit-serial modular multiplier, one bit of b per cycle, msb first
module msr_mulmod #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] p,
  output logic         busy,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  bsh;
  logic [CW-1:0] cnt;
  logic [W+1:0]  dbl;
  logic [W+1:0]  dred;
  logic [W+1:0]  add;
  logic [W+1:0]  acc_next;

  always_comb begin
    dbl = {2'b00, acc} << 1;
    dred = (dbl >= {2'b00, p}) ? dbl - {2'b00, p} : dbl;
    add = dred + (bsh[W-1] ? {2'b00, a} : '0);
    acc_next = (add >= {2'b00, p}) ? add - {2'b00, p} : add;
  end

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      bsh <= b;
    end else if (busy) begin
      acc <= acc_next[W-1:0];
      bsh <= bsh << 1;
    end
  end

endmodule

// ===== sv/modular_square_root.sv =====
// Modular square root by Tonelli-Shanks over a prime modulus (2, 3 mod 4, or 1 mod 4).
// One item is worked at a time. Every modular product goes through a single bit-serial
// multiplier. The input reduction is a bit-serial remainder, and p = 2 finishes after it.
// An exponentiation by a 31-bit exponent takes up to about 2*MOD_WIDTH products, and
// p = 3 mod 4 needs one of them plus a check. For p = 1 mod 4 one exponentiation runs
// for each candidate z until a non-residue is found, and three more follow, then the
// squaring loops add up to about S*S/2 products where p-1 = Q*2^S. The result is held
// in an output register until taken; the next item is accepted while it waits, and a
// finished item waits for that register.
module modular_square_root #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [((2*MOD_WIDTH+7)/8)*8-1:0] s_tdata,  // value, modulus, zero fill
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [((MOD_WIDTH+7)/8)*8-1:0]   m_tdata,  // root, zero fill
  output logic                   m_tuser   // no_root
);

  localparam int W = MOD_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam int OW = ((W + 7) / 8) * 8;

  msr_pkg::state_t state, state_next;
  msr_pkg::state_t ret;
  msr_pkg::pdest_t pdest;

  logic [W-1:0] n, p, q, z, c, t, r, b, sq;
  logic [CW-1:0] s, k, i;
  logic [W-1:0] pacc, pbase, pexp;
  logic [W-1:0] ma, mb;
  logic         mstart, mbusy;
  logic [W-1:0] mprod;
  logic [W-1:0] rem;
  logic [W-1:0] nsh;
  logic [CW-1:0] rcnt;
  logic [W:0]   rtry;
  logic [1:0]   mstep;
  logic         no_root;
  logic [W-1:0] root;
  logic         out_free;

  msr_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .p(p),
    .busy(mbusy), .prod(mprod)
  );

  assign s_tready = (state == msr_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign rtry = {rem, nsh[W-1]};

  always_comb begin
    state_next = state;
    unique case (state)
      msr_pkg::S_IDLE: if (s_tvalid && s_tready) state_next = msr_pkg::S_RED;
      msr_pkg::S_RED:  if (rcnt == '0) state_next = msr_pkg::S_DISP;
      msr_pkg::S_DISP: begin
        if (p < W'(3)) state_next = msr_pkg::S_DONE;
        else if (p[1:0] == 2'b11) state_next = msr_pkg::S_POW;
        else state_next = msr_pkg::S_QS;
      end
      msr_pkg::S_POW:
        state_next = (pexp == '0) ? msr_pkg::S_POWW : msr_pkg::S_MULW;
      msr_pkg::S_MUL:
        state_next = (mstep == 2'd0) ? msr_pkg::S_MULW : msr_pkg::S_POW;
      msr_pkg::S_MULW: if (!mbusy && !mstart) state_next = ret;
      msr_pkg::S_POWW: begin
        unique case (pdest)
          msr_pkg::P_C3: state_next = msr_pkg::S_MULW;
          msr_pkg::P_Z:
            state_next = (pacc == W'(1)) ? msr_pkg::S_ZNEXT : msr_pkg::S_CQ;
          msr_pkg::P_C: state_next = msr_pkg::S_TQ;
          msr_pkg::P_T: state_next = msr_pkg::S_RQ;
          msr_pkg::P_R: state_next = msr_pkg::S_LOOP;
          default: state_next = msr_pkg::S_DONE;
        endcase
      end
      msr_pkg::S_C3:    state_next = msr_pkg::S_DONE;
      msr_pkg::S_QS:    if (q[0]) state_next = msr_pkg::S_ZTEST;
      msr_pkg::S_ZTEST: state_next = msr_pkg::S_POW;
      msr_pkg::S_ZNEXT: state_next = msr_pkg::S_ZTEST;
      msr_pkg::S_CQ:    state_next = msr_pkg::S_POW;
      msr_pkg::S_TQ:    state_next = msr_pkg::S_POW;
      msr_pkg::S_RQ:    state_next = msr_pkg::S_POW;
      msr_pkg::S_LOOP:
        state_next = (t > W'(1)) ? msr_pkg::S_KCHK : msr_pkg::S_DONE;
      msr_pkg::S_KCHK: begin
        if (sq != W'(1) && k <= s) state_next = msr_pkg::S_MULW;
        else if (k >= s) state_next = msr_pkg::S_DONE;
        else state_next = msr_pkg::S_BSQ;
      end
      msr_pkg::S_KSQ:  state_next = msr_pkg::S_KCHK;
      msr_pkg::S_BSQ:
        state_next = (i + 1'b1 < s - k) ? msr_pkg::S_MULW : msr_pkg::S_UPD1;
      msr_pkg::S_UPD1: state_next = msr_pkg::S_MULW;
      msr_pkg::S_UPD2: state_next = msr_pkg::S_MULW;
      msr_pkg::S_UPD3:
        state_next = (mstep == 2'd3) ? msr_pkg::S_LOOP : msr_pkg::S_MULW;
      msr_pkg::S_DONE: if (out_free) state_next = msr_pkg::S_IDLE;
      default: state_next = state;
    endcase
  end

  // control is a single sequencer; multiplications return through ret
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msr_pkg::S_IDLE;
      m_tvalid <= 1'b0;
      mstart <= 1'b0;
    end else begin
      state <= state_next;
      mstart <= (state_next == msr_pkg::S_MULW) && (state != msr_pkg::S_MULW);
      if (state == msr_pkg::S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        msr_pkg::S_IDLE: if (s_tvalid && s_tready) begin
          n <= '0;
          p <= s_tdata[W +: W];
          nsh <= s_tdata[W-1:0];
          rem <= '0;
          rcnt <= CW'(W);
        end
        msr_pkg::S_RED: if (rcnt != '0) begin
          rem <= (rtry >= {1'b0, p}) ? W'(rtry - {1'b0, p}) : rtry[W-1:0];
          nsh <= nsh << 1;
          rcnt <= rcnt - 1'b1;
        end
        msr_pkg::S_DISP: begin
          n <= rem;
          no_root <= (p < W'(2));
          root <= (p == W'(2)) ? {{(W-1){1'b0}}, rem[0]} : '0;
          if (p[1:0] == 2'b11) begin
            pbase <= rem;
            pexp <= W'(({1'b0, p} + 1'b1) >> 2);
            pacc <= W'(1);
            pdest <= msr_pkg::P_C3;
          end else if (p > W'(2)) begin
            q <= p - 1'b1;
            s <= '0;
          end
        end
        // square-and-multiply, lsb first
        msr_pkg::S_POW: begin
          if (pexp != '0) begin
            mstep <= pexp[0] ? 2'd0 : 2'd1;
            ma <= pexp[0] ? pacc : pbase;
            mb <= pbase;
            ret <= msr_pkg::S_MUL;
          end
        end
        msr_pkg::S_MUL: begin
          if (mstep == 2'd0) begin
            pacc <= mprod;
            ma <= pbase; mb <= pbase; mstep <= 2'd1;
            ret <= msr_pkg::S_MUL;
          end else begin
            pbase <= mprod;
            pexp <= pexp >> 1;
          end
        end
        msr_pkg::S_POWW: begin
          unique case (pdest)
            msr_pkg::P_C3: begin
              r <= pacc; ma <= pacc; mb <= pacc;
              ret <= msr_pkg::S_C3;
            end
            msr_pkg::P_Z: ;
            msr_pkg::P_C: c <= pacc;
            msr_pkg::P_T: t <= pacc;
            msr_pkg::P_R: r <= pacc;
            default: ;
          endcase
        end
        msr_pkg::S_C3: begin
          if (mprod == n) root <= r;
          else no_root <= 1'b1;
        end
        msr_pkg::S_QS: begin
          if (q[0]) begin
            z <= W'(2);
          end else begin
            q <= q >> 1;
            s <= s + 1'b1;
          end
        end
        msr_pkg::S_ZTEST: begin
          pbase <= z; pexp <= (p - 1'b1) >> 1; pacc <= W'(1);
          pdest <= msr_pkg::P_Z;
        end
        msr_pkg::S_ZNEXT: begin
          z <= z + 1'b1;
        end
        msr_pkg::S_CQ: begin
          pbase <= z; pexp <= q; pacc <= W'(1);
          pdest <= msr_pkg::P_C;
        end
        msr_pkg::S_TQ: begin
          pbase <= n; pexp <= q; pacc <= W'(1);
          pdest <= msr_pkg::P_T;
        end
        msr_pkg::S_RQ: begin
          pbase <= n; pexp <= W'(({1'b0, q} + 1'b1) >> 1); pacc <= W'(1);
          pdest <= msr_pkg::P_R;
        end
        msr_pkg::S_LOOP: begin
          if (t > W'(1)) begin
            k <= '0; sq <= t;
          end else begin
            root <= (t == W'(1)) ? r : '0;
          end
        end
        // find least k with t^(2^k) == 1
        msr_pkg::S_KCHK: begin
          if (sq != W'(1) && k <= s) begin
            ma <= sq; mb <= sq;
            ret <= msr_pkg::S_KSQ;
          end else if (k >= s) begin
            no_root <= 1'b1;
          end else begin
            b <= c; i <= '0;
          end
        end
        msr_pkg::S_KSQ: begin
          sq <= mprod; k <= k + 1'b1;
        end
        msr_pkg::S_BSQ: begin
          if (i != '0) b <= mprod;
          if (i + 1'b1 < s - k) begin
            ma <= (i != '0) ? mprod : b;
            mb <= (i != '0) ? mprod : b;
            i <= i + 1'b1;
            ret <= msr_pkg::S_BSQ;
          end
        end
        msr_pkg::S_UPD1: begin
          s <= k;
          ma <= b; mb <= b;
          ret <= msr_pkg::S_UPD2;
        end
        msr_pkg::S_UPD2: begin
          c <= mprod;
          ma <= t; mb <= mprod;
          ret <= msr_pkg::S_UPD3;
        end
        msr_pkg::S_UPD3: begin
          if (mstep == 2'd3) begin
            r <= mprod; mstep <= 2'd0;
          end else begin
            t <= mprod;
            ma <= r; mb <= b; mstep <= 2'd3;
            ret <= msr_pkg::S_UPD3;
          end
        end
        msr_pkg::S_DONE: if (out_free) begin
          m_tdata <= no_root ? '0 : OW'(root);
          m_tuser <= no_root;
        end
        default: ;
      endcase
    end
  end

endmodule
